FILE: rtl/sqrot_pkg.sv
package sqrot_pkg;

	localparam int MAX_SIDE    = 8;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int COORD_W     = $clog2(MAX_SIDE);
	localparam int DATA_W      = 32;
	localparam int SIDE_W      = 4;
	localparam int TURN_W      = 2;
	localparam int CFG_W       = 4;
	localparam int INDEX_W     = 1;

	localparam logic [SIDE_W-1:0] SIDE_RESET  = SIDE_W'(MAX_SIDE);
	localparam logic [TURN_W-1:0] TURNS_RESET = TURN_W'(1);

	typedef enum logic [INDEX_W-1:0] {
		REG_SIDE_LENGTH   = 1'b0,
		REG_QUARTER_TURNS = 1'b1
	} reg_index_t;

	typedef enum logic [TURN_W-1:0] {
		TURN_NONE  = 2'd0,
		TURN_ONE   = 2'd1,
		TURN_TWO   = 2'd2,
		TURN_THREE = 2'd3
	} turns_t;

	// Controller to datapath.
	typedef struct packed {
		logic emit_en;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic load_done;
		logic last_read;
	} dp_status_t;

endpackage

FILE: rtl/sqrot_ctrl.sv
module sqrot_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sqrot_pkg::dp_status_t sts,
	output sqrot_pkg::ctl_cmd_t   cmd
);
	import sqrot_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			emit_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (sts.load_done) begin
						state_q <= ST_EMIT;
						emit_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					// The store is free again once its last entry has been read.
					if (sts.last_read) begin
						state_q <= ST_LOAD;
						emit_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					emit_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.emit_en = emit_q;

endmodule

FILE: rtl/sqrot_datapath.sv
module sqrot_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [sqrot_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [sqrot_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                  element_valid,
	input  logic signed [sqrot_pkg::DATA_W-1:0]   element_value,
	output logic                                  rotated_valid,
	input  logic                                  rotated_stall,
	output logic signed [sqrot_pkg::DATA_W-1:0]   rotated_value,
	output logic                                  final_element,
	input  sqrot_pkg::ctl_cmd_t                   cmd,
	output sqrot_pkg::dp_status_t                 sts
);
	import sqrot_pkg::*;

	localparam int PROD_W = COORD_W + SIDE_W;

	logic [SIDE_W-1:0]  side_cfg_q;
	logic [TURN_W-1:0]  turns_cfg_q;
	logic [SIDE_W-1:0]  side_eff;
	logic [COUNT_W-1:0] total;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               accept;
	logic               load_done;

	logic [DATA_W-1:0]  element_store_q [STORE_DEPTH];

	logic [SIDE_W-1:0]  side_q;
	turns_t             turns_q;
	logic [COORD_W-1:0] side_m1;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] src_row;
	logic [COORD_W-1:0] src_col;
	logic [PROD_W-1:0]  row_base;
	logic [ADDR_W-1:0]  rd_addr;
	logic               last_pos;
	logic               rd_en;

	logic [DATA_W-1:0]  rd_data_s1;
	logic               rd_final_s1;
	logic               rd_valid_s1;
	logic               out_load;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_final_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg_q  <= SIDE_RESET;
			turns_cfg_q <= TURNS_RESET;
		end else if (cfg_write_en) begin
			case (reg_index_t'(cfg_index))
				REG_SIDE_LENGTH:   side_cfg_q  <= cfg_data[SIDE_W-1:0];
				REG_QUARTER_TURNS: turns_cfg_q <= cfg_data[TURN_W-1:0];
				default: ;
			endcase
		end
	end

	// A side of zero counts as one; anything above the maximum saturates.
	always_comb begin
		if (side_cfg_q == '0)
			side_eff = SIDE_W'(1);
		else if (side_cfg_q > SIDE_W'(MAX_SIDE))
			side_eff = SIDE_W'(MAX_SIDE);
		else
			side_eff = side_cfg_q;
	end

	assign total      = COUNT_W'(side_eff) * COUNT_W'(side_eff);
	assign count_next = count_q + COUNT_W'(1);
	assign accept     = element_valid && !cmd.emit_en;
	assign load_done  = accept && (count_next >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (accept)
			count_q <= load_done ? '0 : count_next;
	end

	always_ff @(posedge clk) begin
		if (accept)
			element_store_q[count_q[ADDR_W-1:0]] <= element_value;
		if (rd_en)
			rd_data_s1 <= element_store_q[rd_addr];
	end

	// Geometry and turn count are frozen for the whole burst.
	always_ff @(posedge clk) begin
		if (load_done) begin
			side_q  <= side_eff;
			turns_q <= turns_t'(turns_cfg_q);
		end
	end

	assign side_m1  = COORD_W'(side_q - SIDE_W'(1));
	assign last_pos = (row_q == side_m1) && (col_q == side_m1);
	assign rd_en    = cmd.emit_en && (!rd_valid_s1 || out_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (load_done) begin
			row_q <= '0;
			col_q <= '0;
		end else if (rd_en) begin
			if (col_q == side_m1) begin
				col_q <= '0;
				row_q <= row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	always_comb begin
		case (turns_q)
			TURN_NONE: begin
				src_row = row_q;
				src_col = col_q;
			end
			TURN_ONE: begin
				src_row = side_m1 - col_q;
				src_col = row_q;
			end
			TURN_TWO: begin
				src_row = side_m1 - row_q;
				src_col = side_m1 - col_q;
			end
			default: begin
				src_row = col_q;
				src_col = side_m1 - row_q;
			end
		endcase
	end

	assign row_base = PROD_W'(src_row) * PROD_W'(side_q);
	assign rd_addr  = row_base[ADDR_W-1:0] + ADDR_W'(src_col);

	// Read stage and output register form a two-entry pipe, so a stalled
	// beat never drops the word already fetched from the store.
	assign out_load = rd_valid_s1 && (!out_valid_q || !rotated_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_valid_s1 <= 1'b1;
			else if (out_load)
				rd_valid_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!rotated_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_final_s1 <= last_pos;
		if (out_load) begin
			out_data_q  <= rd_data_s1;
			out_final_q <= rd_final_s1;
		end
	end

	assign rotated_valid = out_valid_q;
	assign rotated_value = out_data_q;
	assign final_element = out_final_q;

	assign sts.load_done = load_done;
	assign sts.last_read = rd_en && last_pos;

endmodule

FILE: rtl/square_matrix_rotator.sv
// Loads a side*side matrix of signed 32-bit elements in row-major order, one beat per cycle
// while element_stall is low, then streams it out turned clockwise by quarter_turns quarter
// turns, in row-major order, with final_element set on the last beat. Once the last element
// is in, element_stall stays high while the single-port element store is read out at one
// entry per cycle unless rotated_stall holds the output back; each entry passes through the
// read stage and the output register on its way out. The side (saturated to 1..8) and the
// turn count are sampled when the last element is taken.
module square_matrix_rotator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [sqrot_pkg::INDEX_W-1:0]       cfg_index,
	input  logic [sqrot_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                element_valid,
	output logic                                element_stall,
	input  logic signed [sqrot_pkg::DATA_W-1:0] element_value,
	output logic                                rotated_valid,
	input  logic                                rotated_stall,
	output logic signed [sqrot_pkg::DATA_W-1:0] rotated_value,
	output logic                                final_element
);
	import sqrot_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;

	sqrot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sqrot_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_valid (element_valid),
		.element_value (element_value),
		.rotated_valid (rotated_valid),
		.rotated_stall (rotated_stall),
		.rotated_value (rotated_value),
		.final_element (final_element),
		.cmd           (cmd),
		.sts           (sts)
	);

	assign element_stall = cmd.emit_en;

`ifndef SYNTHESIS
	a_load_done_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.load_done |=> element_stall)
		else $error("input not stalled after a completed load");

	a_last_read_ends_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.last_read |=> !element_stall)
		else $error("input still stalled after the last store read");

	a_load_only_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		sts.load_done |-> !element_stall)
		else $error("load completed during emission");

	a_read_only_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.last_read |-> element_stall)
		else $error("store read issued outside emission");
`endif

endmodule

FILE: verif/square_matrix_rotator_test.sv
module square_matrix_rotator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sqrot_pkg::*;

	localparam int RANDOM_ITEMS = 330;
	localparam int CALM_AFTER   = 260;
	localparam int QUIET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} rotated_beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [INDEX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     element_valid = 1'b0;
	logic                     element_stall;
	logic signed [DATA_W-1:0] element_value = '0;
	logic                     rotated_valid;
	logic                     rotated_stall = 1'b0;
	logic signed [DATA_W-1:0] rotated_value;
	logic                     final_element;

	// Expected behavior: a private copy of the element store and the registers.
	logic [DATA_W-1:0]  matrix_copy [STORE_DEPTH];
	logic [COUNT_W-1:0] loaded_count = '0;
	logic [SIDE_W-1:0]  side_setting = SIDE_RESET;
	turns_t             turns_setting = turns_t'(TURNS_RESET);

	logic [DATA_W-1:0] element_queue [$];
	rotated_beat_t     expected_beats [$];
	rotated_beat_t     want;

	int fail_count = 0;
	int cycle_count = 0;
	int stim_count = 0;
	int gap_left = 0;
	int hold_left = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	bit calm = 1'b0;

	square_matrix_rotator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_valid (element_valid),
		.element_stall (element_stall),
		.element_value (element_value),
		.rotated_valid (rotated_valid),
		.rotated_stall (rotated_stall),
		.rotated_value (rotated_value),
		.final_element (final_element)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_side(logic [SIDE_W-1:0] raw);
		if (raw == 0) begin
			return 1;
		end
		if (raw > MAX_SIDE) begin
			return MAX_SIDE;
		end
		return int'(raw);
	endfunction

	// Stores one element; when the load is complete, queues the rotated matrix.
	function automatic void load_and_rotate(logic [DATA_W-1:0] v);
		int n;
		int total;
		int sr;
		int sc;
		int k;
		rotated_beat_t beat;
		n = eff_side(side_setting);
		total = n * n;
		matrix_copy[loaded_count[ADDR_W-1:0]] = v;
		loaded_count = loaded_count + 1'b1;
		if (loaded_count < total) begin
			return;
		end
		k = 0;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				case (turns_setting)
					TURN_NONE: begin
						sr = r;
						sc = c;
					end
					TURN_ONE: begin
						sr = n - 1 - c;
						sc = r;
					end
					TURN_TWO: begin
						sr = n - 1 - r;
						sc = n - 1 - c;
					end
					default: begin
						sr = c;
						sc = n - 1 - r;
					end
				endcase
				k++;
				beat.value = matrix_copy[(sr * n + sc) % STORE_DEPTH];
				beat.last = (k == total);
				expected_beats.push_back(beat);
			end
		end
		loaded_count = '0;
	endfunction

	function automatic logic [DATA_W-1:0] random_element();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Called at a falling edge so the driver never pops in the same step.
	task automatic push_elements(input int count);
		repeat (count) begin
			element_queue.push_back(random_element());
			stim_count++;
		end
	endtask

	task automatic finish_load();
		int total;
		total = eff_side(side_setting) * eff_side(side_setting);
		if (loaded_count >= total) begin
			push_elements(1);
		end else begin
			push_elements(total - int'(loaded_count));
		end
	endtask

	task automatic wait_quiet();
		do begin
			@(negedge clk);
		end while (element_queue.size() != 0 || element_valid || expected_beats.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_SIDE_LENGTH) begin
			side_setting = val[SIDE_W-1:0];
		end else begin
			turns_setting = turns_t'(val[TURN_W-1:0]);
		end
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	// Input side: one beat at a time, with random bursts of idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_valid <= 1'b0;
			gap_left = 0;
		end else if (!element_valid || !element_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				element_valid <= 1'b0;
			end else if (!calm && $urandom_range(99) < in_idle_pct) begin
				gap_left = $urandom_range(9);
				element_valid <= 1'b0;
			end else if (element_queue.size() != 0) begin
				element_value <= element_queue.pop_front();
				element_valid <= 1'b1;
			end else begin
				element_valid <= 1'b0;
			end
		end
	end

	// Output side: stall in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotated_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			rotated_stall <= 1'b1;
		end else if (!calm && $urandom_range(99) < out_idle_pct) begin
			hold_left = $urandom_range(9);
			rotated_stall <= 1'b1;
		end else begin
			rotated_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (element_valid && !element_stall) begin
				load_and_rotate(element_value);
			end
			if (rotated_valid && !rotated_stall) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected rotated beat: value %0d final %0b",
						rotated_value, final_element);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (rotated_value !== want.value) begin
						$error("rotated_value: expected %0d, actual %0d",
							want.value, rotated_value);
						fail_count++;
					end
					if (final_element !== want.last) begin
						$error("final_element: expected %0b, actual %0b",
							want.last, final_element);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int total;
		int partial;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One full matrix at the reset settings.
		push_elements(MAX_SIDE * MAX_SIDE);
		wait_quiet();

		// A side of zero behaves as a side of one.
		write_reg(REG_SIDE_LENGTH, 4'd0);
		write_reg(REG_QUARTER_TURNS, TURN_NONE);
		element_queue.push_back(32'h8000_0000);
		wait_quiet();
		write_reg(REG_SIDE_LENGTH, 4'd1);
		element_queue.push_back(32'h7fff_ffff);
		element_queue.push_back(32'h0000_0000);
		wait_quiet();

		write_reg(REG_SIDE_LENGTH, 4'd2);
		for (int t = 1; t < 4; t++) begin
			write_reg(REG_QUARTER_TURNS, CFG_W'(t));
			for (int i = 0; i < 4; i++) begin
				element_queue.push_back(32'(10 * t + i));
			end
			wait_quiet();
		end

		// The turn count in force when the last element arrives is the one used.
		write_reg(REG_QUARTER_TURNS, TURN_NONE);
		element_queue.push_back(32'hffff_ffff);
		element_queue.push_back(32'h8000_0001);
		wait_quiet();
		write_reg(REG_QUARTER_TURNS, TURN_TWO);
		element_queue.push_back(32'h7fff_fffe);
		element_queue.push_back(32'h0000_0001);
		wait_quiet();

		// Shrinking the side mid-load past the count already stored completes the load on the next element.
		write_reg(REG_SIDE_LENGTH, 4'd3);
		push_elements(5);
		wait_quiet();
		write_reg(REG_SIDE_LENGTH, 4'd2);
		finish_load();
		wait_quiet();

		// A side above the maximum saturates.
		write_reg(REG_SIDE_LENGTH, 4'd15);
		write_reg(REG_QUARTER_TURNS, TURN_THREE);
		push_elements(MAX_SIDE * MAX_SIDE);
		wait_quiet();

		while (stim_count < RANDOM_ITEMS) begin
			if (stim_count > CALM_AFTER) begin
				calm = 1'b1;
			end
			in_idle_pct = pick_idle_pct();
			out_idle_pct = pick_idle_pct();
			if ($urandom_range(3) == 0) begin
				write_reg(REG_SIDE_LENGTH, CFG_W'($urandom_range(15)));
			end else begin
				write_reg(REG_SIDE_LENGTH, CFG_W'($urandom_range(4, 1)));
			end
			if ($urandom_range(2) != 0) begin
				write_reg(REG_QUARTER_TURNS, CFG_W'($urandom_range(3)));
			end
			total = eff_side(side_setting) * eff_side(side_setting);
			repeat ($urandom_range(3, 1)) push_elements(total);
			if (total > 1 && $urandom_range(3) == 0) begin
				partial = $urandom_range(total - 1, 1);
				push_elements(partial);
				wait_quiet();
				write_reg(REG_SIDE_LENGTH, CFG_W'($urandom_range(MAX_SIDE, 1)));
				if ($urandom_range(1) == 0) begin
					write_reg(REG_QUARTER_TURNS, CFG_W'($urandom_range(3)));
				end
				finish_load();
			end
			wait_quiet();
		end

		if (fail_count == 0 && expected_beats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: square_matrix_rotator.f
rtl/sqrot_pkg.sv
rtl/sqrot_ctrl.sv
rtl/sqrot_datapath.sv
rtl/square_matrix_rotator.sv
verif/square_matrix_rotator_test.sv
